// ----- src/gcbq_pkg.sv -----
// Shared types, constants and step-offset functions for the grid cell blocking query block.
package gcbq_pkg;

  localparam int OPCODE_W  = 3;
  localparam int COORD_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 32;
  localparam int STEP_W    = 4;

  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam int ST_OPEN   = 0;
  localparam int ST_CLOSED = 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 3'd0,
    OP_FILL  = 3'd1,
    OP_READ  = 3'd2,
    OP_BLOCK = 3'd3,
    OP_TOUCH = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_BLOCK = 2'd1,
    MODE_TOUCH = 2'd2
  } walk_mode_e;

  typedef struct packed {
    logic       clear;
    logic       valid;
    logic       first;
    logic       on_grid;
    walk_mode_e mode;
  } eval_ctrl_t;

  localparam logic signed [1:0] RING_DX [8] = '{
    2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1
  };
  localparam logic signed [1:0] RING_DY [8] = '{
    2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1
  };

  function automatic logic [STEP_W-1:0] walk_len(walk_mode_e mode);
    logic [STEP_W-1:0] len;
    case (mode)
      MODE_READ:  len = 4'd1;
      MODE_BLOCK: len = 4'd9;
      MODE_TOUCH: len = 4'd4;
      default:    len = 4'd1;
    endcase
    return len;
  endfunction

  // The blocking walk starts on the last ring position and then goes round the ring.
  function automatic logic [2:0] ring_index(logic [STEP_W-1:0] step);
    logic [2:0] ri;
    if (step == '0) begin
      ri = 3'd7;
    end else begin
      ri = 3'(step - 4'd1);
    end
    return ri;
  endfunction

  function automatic logic signed [1:0] step_dx(walk_mode_e mode, logic [STEP_W-1:0] step);
    logic signed [1:0] dx;
    case (mode)
      MODE_BLOCK: dx = RING_DX[ring_index(step)];
      MODE_TOUCH: begin
        case (step[1:0])
          2'd0:    dx = -2'sd1;
          2'd1:    dx = 2'sd1;
          default: dx = 2'sd0;
        endcase
      end
      default:    dx = 2'sd0;
    endcase
    return dx;
  endfunction

  function automatic logic signed [1:0] step_dy(walk_mode_e mode, logic [STEP_W-1:0] step);
    logic signed [1:0] dy;
    case (mode)
      MODE_BLOCK: dy = RING_DY[ring_index(step)];
      MODE_TOUCH: begin
        case (step[1:0])
          2'd2:    dy = -2'sd1;
          2'd3:    dy = 2'sd1;
          default: dy = 2'sd0;
        endcase
      end
      default:    dy = 2'sd0;
    endcase
    return dy;
  endfunction

endpackage

// ----- src/gcbq_ring_eval.sv -----
// Accumulator that evaluates the cells read during a read, blocking or touching walk.
module gcbq_ring_eval #(
  parameter int STATUS_BITS = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gcbq_pkg::eval_ctrl_t          ctrl_i,
  input  logic [STATUS_BITS-1:0]        rd_data_i,
  input  logic [STATUS_BITS-1:0]        code_i,
  output logic [gcbq_pkg::STATUS_W-1:0] cell_value_o,
  output logic                          is_blocking_o,
  output logic                          is_touching_o
);
  import gcbq_pkg::*;

  logic [STATUS_BITS-1:0] prev_q;
  logic [STATUS_BITS-1:0] value_q;
  logic [1:0]             rises_q;
  logic                   touch_q;
  logic [STATUS_BITS-1:0] cur;
  logic                   rise;
  logic [STATUS_BITS+STATUS_W-1:0] value_wide;

  assign cur  = ctrl_i.on_grid ? rd_data_i : STATUS_BITS'(ST_CLOSED);
  assign rise = !ctrl_i.first && ctrl_i.on_grid && (rd_data_i == STATUS_BITS'(ST_OPEN)) &&
                (prev_q == STATUS_BITS'(ST_CLOSED));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      value_q <= '0;
      rises_q <= '0;
      touch_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      prev_q  <= '0;
      value_q <= '0;
      rises_q <= '0;
      touch_q <= 1'b0;
    end else if (ctrl_i.valid) begin
      case (ctrl_i.mode)
        MODE_READ: begin
          value_q <= rd_data_i;
        end
        MODE_BLOCK: begin
          prev_q <= cur;
          if (rise && rises_q != 2'd2) begin
            rises_q <= rises_q + 2'd1;
          end
        end
        MODE_TOUCH: begin
          if (ctrl_i.on_grid && rd_data_i == code_i) begin
            touch_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign value_wide    = {{STATUS_W{1'b0}}, value_q};
  assign cell_value_o  = value_wide[STATUS_W-1:0];
  assign is_blocking_o = rises_q[1];
  assign is_touching_o = touch_q;

  a_rises_saturate : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rises_q != 2'd3)
    else $error("Transition count went past saturation.");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (rises_q == 2'd0 && !touch_q && value_q == '0))
    else $error("Accumulators not empty after clear.");

  a_first_no_rise : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.valid && !ctrl_i.clear && ctrl_i.first && ctrl_i.mode == MODE_BLOCK)
    |=> $stable(rises_q))
    else $error("Starting cell of the ring counted a transition.");

  a_off_grid_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.valid && !ctrl_i.clear && !ctrl_i.on_grid && ctrl_i.mode == MODE_BLOCK)
    |=> prev_q == STATUS_BITS'(ST_CLOSED))
    else $error("Off-grid neighbor not taken as closed.");

endmodule

// ----- src/grid_cell_blocking_query_top.sv -----
// Top level of the grid cell blocking query block with its cell memory and sequencer.
//
// The grid lives in one synchronous memory of MAX_COLS*MAX_ROWS cells with one write
// and one read port, and queries read one cell per cycle. After reset the block runs
// a clearing pass over every cell and takes no input word until it ends;
// configuration writes are taken at any time. A write or an unknown opcode goes
// straight to the result; a read query reads one cell, a touching query four
// neighbors and a blocking query nine neighbor positions, and a fill writes every
// cell of the width*height area in use.
// One result word follows each input word; a finished result waits in an output
// register while the next input word is already being taken.
module grid_cell_blocking_query_top #(
  parameter int MAX_COLS    = 256,
  parameter int MAX_ROWS    = 256,
  parameter int STATUS_BITS = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gcbq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gcbq_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gcbq_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [gcbq_pkg::COORD_W-1:0]   col_i,
  input  logic [gcbq_pkg::COORD_W-1:0]   row_i,
  input  logic [gcbq_pkg::STATUS_W-1:0]  status_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [gcbq_pkg::STATUS_W-1:0]  cell_value_o,
  output logic                           is_blocking_o,
  output logic                           is_touching_o,
  output logic [gcbq_pkg::COUNT_W-1:0]   change_count_o,
  output logic                           out_of_range_o
);
  import gcbq_pkg::*;

  localparam int CIW   = $clog2(MAX_COLS);
  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ((CIW > COORD_W) ? CIW : COORD_W) + 2;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FILL   = 6'b000100,
    S_WALK   = 6'b001000,
    S_LAST   = 6'b010000,
    S_RESULT = 6'b100000
  } state_e;

  function automatic logic on_grid(logic signed [XW-1:0] x, logic signed [XW-1:0] y,
                                   logic signed [XW-1:0] cols, logic signed [XW-1:0] rows);
    return !x[XW-1] && !y[XW-1] && (x < cols) && (y < rows);
  endfunction

  function automatic logic [AW-1:0] addr_of(logic [XW-1:0] x, logic [XW-1:0] y);
    return AW'(y) * AW'(MAX_COLS) + AW'(x);
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0]       grid_width_q, grid_height_q;
  logic signed [XW-1:0]   cols_used, rows_used;

  logic [COORD_W-1:0]     col_q, col_d, row_q, row_d;
  logic [STATUS_BITS-1:0] code_q, code_d, code_in;
  logic [STATUS_BITS+STATUS_W-1:0] code_wide;
  walk_mode_e             mode_q, mode_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   pend_q, pend_d, pend_first_q, pend_first_d, pend_on_q, pend_on_d;
  logic                   oor_q, oor_d;
  logic [CIW-1:0]         fill_col_q, fill_col_d;
  logic [RIW-1:0]         fill_row_q, fill_row_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [COUNT_W-1:0]     change_q, change_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    cell_value_q;
  logic                   is_blocking_q, is_touching_q, out_of_range_q;
  logic [COUNT_W-1:0]     change_count_q;
  logic                   out_load;

  logic                   accept;
  logic signed [XW-1:0]   in_x, in_y, nx, ny;
  logic                   in_on, n_on;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [STATUS_BITS-1:0] mem_wdata, rd_data_q;
  logic [STATUS_BITS-1:0] cell_mem [DEPTH];

  eval_ctrl_t             eval_ctrl;
  logic [STATUS_W-1:0]    eval_value;
  logic                   eval_blocking, eval_touching;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_RESET;
      grid_height_q <= GRID_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (grid_width_q == '0) begin
      cols_used = XW'(1);
    end else if (32'(grid_width_q) > MAX_COLS) begin
      cols_used = XW'(MAX_COLS);
    end else begin
      cols_used = XW'(grid_width_q);
    end
    if (grid_height_q == '0) begin
      rows_used = XW'(1);
    end else if (32'(grid_height_q) > MAX_ROWS) begin
      rows_used = XW'(MAX_ROWS);
    end else begin
      rows_used = XW'(grid_height_q);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign code_wide  = {{STATUS_BITS{1'b0}}, status_value_i};
  assign code_in    = code_wide[STATUS_BITS-1:0];
  assign in_x       = $signed({{(XW-COORD_W){1'b0}}, col_i});
  assign in_y       = $signed({{(XW-COORD_W){1'b0}}, row_i});
  assign in_on      = on_grid(in_x, in_y, cols_used, rows_used);
  assign nx         = $signed({{(XW-COORD_W){1'b0}}, col_q}) + XW'(step_dx(mode_q, step_q));
  assign ny         = $signed({{(XW-COORD_W){1'b0}}, row_q}) + XW'(step_dy(mode_q, step_q));
  assign n_on       = on_grid(nx, ny, cols_used, rows_used);
  assign out_load   = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    code_d       = code_q;
    mode_d       = mode_q;
    step_d       = step_q;
    pend_d       = 1'b0;
    pend_first_d = pend_first_q;
    pend_on_d    = pend_on_q;
    oor_d        = oor_q;
    fill_col_d   = fill_col_q;
    fill_row_d   = fill_row_q;
    clr_d        = clr_q;
    change_d     = change_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_raddr    = '0;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          col_d      = col_i;
          row_d      = row_i;
          code_d     = code_in;
          step_d     = '0;
          fill_col_d = '0;
          fill_row_d = '0;
          oor_d      = 1'b0;
          state_d    = S_RESULT;
          case (opcode_e'(opcode_i))
            OP_WRITE: begin
              oor_d = !in_on;
              if (in_on) begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(in_x, in_y);
                mem_wdata = code_in;
                change_d  = change_q + COUNT_W'(1);
              end
            end
            OP_FILL: begin
              state_d = S_FILL;
            end
            OP_READ: begin
              oor_d   = !in_on;
              mode_d  = MODE_READ;
              state_d = in_on ? S_WALK : S_RESULT;
            end
            OP_BLOCK: begin
              oor_d   = !in_on;
              mode_d  = MODE_BLOCK;
              state_d = in_on ? S_WALK : S_RESULT;
            end
            OP_TOUCH: begin
              oor_d   = !in_on;
              mode_d  = MODE_TOUCH;
              state_d = in_on ? S_WALK : S_RESULT;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(fill_row_q) * AW'(MAX_COLS) + AW'(fill_col_q);
        mem_wdata = code_q;
        if (XW'(fill_col_q) == cols_used - XW'(1)) begin
          fill_col_d = '0;
          if (XW'(fill_row_q) == rows_used - XW'(1)) begin
            change_d = change_q + COUNT_W'(1);
            state_d  = S_RESULT;
          end else begin
            fill_row_d = fill_row_q + RIW'(1);
          end
        end else begin
          fill_col_d = fill_col_q + CIW'(1);
        end
      end
      S_WALK: begin
        mem_raddr    = n_on ? addr_of(nx, ny) : '0;
        pend_d       = 1'b1;
        pend_on_d    = n_on;
        pend_first_d = (step_q == '0);
        step_d       = step_q + STEP_W'(1);
        if (step_q == walk_len(mode_q) - STEP_W'(1)) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      change_q     <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      change_q     <= change_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q        <= col_d;
    row_q        <= row_d;
    code_q       <= code_d;
    mode_q       <= mode_d;
    step_q       <= step_d;
    pend_first_q <= pend_first_d;
    pend_on_q    <= pend_on_d;
    oor_q        <= oor_d;
    fill_col_q   <= fill_col_d;
    fill_row_q   <= fill_row_d;
    if (out_load) begin
      cell_value_q   <= eval_value;
      is_blocking_q  <= eval_blocking;
      is_touching_q  <= eval_touching;
      change_count_q <= change_q;
      out_of_range_q <= oor_q;
    end
  end

  // Writes happen only on acceptance, fill and clear; read addresses are driven only during a walk.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= cell_mem[mem_raddr];
  end

  assign eval_ctrl.clear   = accept;
  assign eval_ctrl.valid   = pend_q;
  assign eval_ctrl.first   = pend_first_q;
  assign eval_ctrl.on_grid = pend_on_q;
  assign eval_ctrl.mode    = mode_q;

  gcbq_ring_eval #(
    .STATUS_BITS(STATUS_BITS)
  ) u_ring_eval (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (eval_ctrl),
    .rd_data_i    (rd_data_q),
    .code_i       (code_q),
    .cell_value_o (eval_value),
    .is_blocking_o(eval_blocking),
    .is_touching_o(eval_touching)
  );

  assign out_valid_o    = out_valid_q;
  assign cell_value_o   = cell_value_q;
  assign is_blocking_o  = is_blocking_q;
  assign is_touching_o  = is_touching_q;
  assign change_count_o = change_count_q;
  assign out_of_range_o = out_of_range_q;

  a_fill_in_area : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (XW'(fill_col_q) < cols_used && XW'(fill_row_q) < rows_used))
    else $error("Fill address left the grid in use.");

  a_change_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (change_q == $past(change_q) || change_q == $past(change_q) + COUNT_W'(1)))
    else $error("Change counter moved by more than one.");

  a_pend_from_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_WALK))
    else $error("Read data evaluated without a walk read.");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESULT))
    else $error("Result word raised outside the result state.");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the grid cell blocking query block.
`timescale 1ns / 100ps

module tb_top;
  import gcbq_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 2;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 8;
  localparam int FILL_CELLS   = 1024;
  localparam int COLS_MAX     = 256;
  localparam int ROWS_MAX     = 256;
  localparam int PAUSE_PHASE  = 0;
  localparam int HOLD_PHASE   = 2;

  localparam logic [OPCODE_W-1:0]  OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0]  OP_SPARE_LAST  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI   = 2'd3;
  localparam logic [STATUS_W-1:0]  CODE_OPEN      = STATUS_W'(ST_OPEN);
  localparam logic [STATUS_W-1:0]  CODE_CLOSED    = STATUS_W'(ST_CLOSED);

  localparam int RING_X [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int RING_Y [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

  typedef struct packed {
    logic [STATUS_W-1:0] cell_value;
    logic                is_blocking;
    logic                is_touching;
    logic [COUNT_W-1:0]  change_count;
    logic                out_of_range;
  } grid_result_t;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [OPCODE_W-1:0]   op;
    logic [COORD_W-1:0]    col;
    logic [COORD_W-1:0]    row;
    logic [STATUS_W-1:0]   status;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_W-1:0]      reg_data;
    bit                    hand_checked;
    grid_result_t          hand;
  } opening_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    logic [15:0]      words;
    logic             quiet;
  } grid_phase_t;

  localparam grid_phase_t PHASE_PLAN [9] = '{
    '{9'd4,   9'd4,   16'd120, 1'b0},
    '{9'd1,   9'd1,   16'd30,  1'b0},
    '{9'd8,   9'd5,   16'd150, 1'b0},
    '{9'd300, 9'd2,   16'd100, 1'b0},
    '{9'd2,   9'd256, 16'd100, 1'b0},
    '{9'd16,  9'd16,  16'd150, 1'b1},
    '{9'd256, 9'd256, 16'd120, 1'b0},
    '{9'd3,   9'd0,   16'd60,  1'b0},
    '{9'd9,   9'd7,   16'd70,  1'b0}
  };

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [OPCODE_W-1:0]  opcode_i       = '0;
  logic [COORD_W-1:0]   col_i          = '0;
  logic [COORD_W-1:0]   row_i          = '0;
  logic [STATUS_W-1:0]  status_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [STATUS_W-1:0]  cell_value_o;
  logic                 is_blocking_o;
  logic                 is_touching_o;
  logic [COUNT_W-1:0]   change_count_o;
  logic                 out_of_range_o;

  // Predicted block state.
  bit   [STATUS_W-1:0] cell_mem [COLS_MAX*ROWS_MAX];
  logic [CFG_W-1:0]    cols_reg     = GRID_RESET;
  logic [CFG_W-1:0]    rows_reg     = GRID_RESET;
  logic [COUNT_W-1:0]  change_total = '0;

  grid_result_t awaited_results [$];
  opening_row_t opening_rows [$];

  logic        quiet_phase    = 1'b0;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned ready_hold     = 0;
  int unsigned cycle_count    = 0;
  int          fail_count     = 0;
  int          results_checked = 0;
  int          oor_seen       = 0;
  int          blocking_seen  = 0;
  int          reg_writes     = 0;
  int          op_seen [8];

  grid_cell_blocking_query_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .status_value_i (status_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_value_o   (cell_value_o),
    .is_blocking_o  (is_blocking_o),
    .is_touching_o  (is_touching_o),
    .change_count_o (change_count_o),
    .out_of_range_o (out_of_range_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int clip_span(logic [CFG_W-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > COLS_MAX) begin
      return COLS_MAX;
    end
    return int'(v);
  endfunction

  function automatic bit on_grid(int x, int y);
    return x >= 0 && y >= 0 && x < clip_span(cols_reg) && y < clip_span(rows_reg);
  endfunction

  function automatic logic [STATUS_W-1:0] cell_at(int x, int y);
    return cell_mem[y * COLS_MAX + x];
  endfunction

  // Off-grid neighbors read as closed; other codes carry over as the previous status.
  function automatic bit ring_blocking(int cx, int cy);
    int rises;
    int x;
    int y;
    logic [STATUS_W-1:0] cur;
    logic [STATUS_W-1:0] prev;
    rises = 0;
    x = cx + RING_X[7];
    y = cy + RING_Y[7];
    cur = on_grid(x, y) ? cell_at(x, y) : CODE_CLOSED;
    for (int i = 0; i < 8; i++) begin
      prev = cur;
      x = cx + RING_X[i];
      y = cy + RING_Y[i];
      if (on_grid(x, y)) begin
        cur = cell_at(x, y);
        if (cur == CODE_OPEN && prev == CODE_CLOSED) begin
          rises++;
        end
      end else begin
        cur = CODE_CLOSED;
      end
    end
    return rises > 1;
  endfunction

  function automatic bit touches_code(logic [STATUS_W-1:0] code, int x, int y);
    int w;
    int h;
    w = clip_span(cols_reg);
    h = clip_span(rows_reg);
    return (x > 0 && cell_at(x - 1, y) == code) || (x < w - 1 && cell_at(x + 1, y) == code)
        || (y > 0 && cell_at(x, y - 1) == code) || (y < h - 1 && cell_at(x, y + 1) == code);
  endfunction

  function automatic grid_result_t step_grid(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] c,
                                             logic [COORD_W-1:0] r, logic [STATUS_W-1:0] s);
    grid_result_t res;
    int x;
    int y;
    res = '0;
    x = int'(c);
    y = int'(r);
    case (op)
      OP_FILL: begin
        for (int j = 0; j < clip_span(rows_reg); j++) begin
          for (int i = 0; i < clip_span(cols_reg); i++) begin
            cell_mem[j * COLS_MAX + i] = s;
          end
        end
        change_total++;
      end
      OP_WRITE, OP_READ, OP_BLOCK, OP_TOUCH: begin
        if (!on_grid(x, y)) begin
          res.out_of_range = 1'b1;
        end else if (op == OP_WRITE) begin
          cell_mem[y * COLS_MAX + x] = s;
          change_total++;
        end else if (op == OP_READ) begin
          res.cell_value = cell_at(x, y);
        end else if (op == OP_BLOCK) begin
          res.is_blocking = ring_blocking(x, y);
        end else begin
          res.is_touching = touches_code(s, x, y);
        end
      end
      default: begin
      end
    endcase
    res.change_count = change_total;
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_phase) begin
      return 0;
    end
    roll = $urandom_range(0, 15);
    if (roll < 10) begin
      return 0;
    end
    if (roll < 14) begin
      return $urandom_range(1, 3);
    end
    if (roll < 15) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Mostly near the anchor so that neighborhoods fill up, some anywhere, some off the grid.
  function automatic logic [COORD_W-1:0] pick_coord(int span, int anchor);
    int v;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      v = anchor + int'($urandom_range(0, 6)) - 3;
      if (v < 0) begin
        v = 0;
      end
      if (v > span - 1) begin
        v = span - 1;
      end
    end else if (roll < 8) begin
      v = int'($urandom_range(0, span - 1));
    end else if (roll == 8) begin
      v = ($urandom_range(0, 1) != 0) ? span - 1 : 0;
    end else begin
      v = int'($urandom_range(0, 255));
    end
    return COORD_W'(v);
  endfunction

  function automatic opening_row_t word_row(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] c,
                                            logic [COORD_W-1:0] r, logic [STATUS_W-1:0] s);
    opening_row_t row_entry;
    row_entry = '{kind: ROW_WORD, default: '0};
    row_entry.op = op;
    row_entry.col = c;
    row_entry.row = r;
    row_entry.status = s;
    return row_entry;
  endfunction

  function automatic opening_row_t checked_row(
      logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] c, logic [COORD_W-1:0] r,
      logic [STATUS_W-1:0] s, logic [STATUS_W-1:0] val, logic blk, logic tch,
      logic [COUNT_W-1:0] cnt, logic oor);
    opening_row_t row_entry;
    row_entry = word_row(op, c, r, s);
    row_entry.hand_checked = 1'b1;
    row_entry.hand = '{val, blk, tch, cnt, oor};
    return row_entry;
  endfunction

  function automatic opening_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    opening_row_t row_entry;
    row_entry = '{kind: ROW_REG, default: '0};
    row_entry.reg_index = idx;
    row_entry.reg_data = data;
    return row_entry;
  endfunction

  task automatic send_word(logic [OPCODE_W-1:0] op, logic [COORD_W-1:0] c,
                           logic [COORD_W-1:0] r, logic [STATUS_W-1:0] s,
                           bit hand_checked, grid_result_t hand);
    grid_result_t predicted;
    int unsigned gap;
    if (cfg_valid_i) begin
      cfg_valid_i <= 1'b0;
    end
    if (!in_valid_i) begin
      in_valid_i <= 1'b1;
    end
    opcode_i       <= op;
    col_i          <= c;
    row_i          <= r;
    status_value_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_grid(op, c, r, s);
    awaited_results.push_back(hand_checked ? hand : predicted);
    op_seen[op]++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (!cfg_valid_i) begin
      cfg_valid_i <= 1'b1;
    end
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_GRID_WIDTH:  cols_reg = data;
      REG_GRID_HEIGHT: rows_reg = data;
      default: begin
      end
    endcase
    reg_writes++;
  endtask

  task automatic drain_results();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic send_random_word(int w, int h, int anchor_c, int anchor_r);
    int unsigned pick;
    int unsigned code_roll;
    logic [OPCODE_W-1:0] op;
    logic [STATUS_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_WRITE;
    end else if (pick < 38) begin
      op = (w * h <= FILL_CELLS) ? OP_FILL : OP_WRITE;
    end else if (pick < 50) begin
      op = OP_READ;
    end else if (pick < 75) begin
      op = OP_BLOCK;
    end else if (pick < 95) begin
      op = OP_TOUCH;
    end else begin
      op = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    code_roll = $urandom_range(0, 9);
    if (code_roll < 4) begin
      s = CODE_OPEN;
    end else if (code_roll < 8) begin
      s = CODE_CLOSED;
    end else begin
      s = STATUS_W'($urandom_range(2, 3));
    end
    send_word(op, pick_coord(w, anchor_c), pick_coord(h, anchor_r), s, 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : ready_side
    int unsigned hold;
    if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold = LONG_HOLD;
    end else if (ready_hold != 0) begin
      hold = ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      hold = pick_gap();
    end else begin
      hold = 0;
    end
    ready_hold  <= hold;
    out_ready_i <= (hold == 0);
  end

  always @(posedge clk_i) begin : result_check
    grid_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result word with no input word outstanding");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        if (want.out_of_range) begin
          oor_seen++;
        end
        if (want.is_blocking) begin
          blocking_seen++;
        end
        check_field("cell_value", want.cell_value, cell_value_o);
        check_field("is_blocking", want.is_blocking, is_blocking_o);
        check_field("is_touching", want.is_touching, is_touching_o);
        check_field("change_count", want.change_count, change_count_o);
        check_field("out_of_range", want.out_of_range, out_of_range_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    opening_row_t entry;
    grid_phase_t  ph;
    int w;
    int h;
    int anchor_c;
    int anchor_r;

    foreach (op_seen[i]) begin
      op_seen[i] = 0;
    end

    // All cells open after reset; the grid starts at full size.
    opening_rows.push_back(checked_row(OP_READ, 8'd0, 8'd0, 2'd0, 2'd0, 0, 0, 32'd0, 0));
    opening_rows.push_back(checked_row(OP_BLOCK, 8'd0, 8'd0, 2'd0, 2'd0, 0, 0, 32'd0, 0));
    opening_rows.push_back(checked_row(OP_WRITE, 8'd255, 8'd255, 2'd3, 2'd0, 0, 0, 32'd1, 0));
    opening_rows.push_back(checked_row(OP_READ, 8'd255, 8'd255, 2'd0, 2'd3, 0, 0, 32'd1, 0));
    opening_rows.push_back(checked_row(OP_WRITE, 8'd0, 8'd0, 2'd1, 2'd0, 0, 0, 32'd2, 0));
    opening_rows.push_back(checked_row(OP_TOUCH, 8'd1, 8'd0, 2'd1, 2'd0, 0, 1, 32'd2, 0));
    // Closed cells left and right of (10,10) give two closed-to-open steps.
    opening_rows.push_back(checked_row(OP_WRITE, 8'd11, 8'd10, 2'd1, 2'd0, 0, 0, 32'd3, 0));
    opening_rows.push_back(checked_row(OP_WRITE, 8'd9, 8'd10, 2'd1, 2'd0, 0, 0, 32'd4, 0));
    opening_rows.push_back(checked_row(OP_BLOCK, 8'd10, 8'd10, 2'd0, 2'd0, 1, 0, 32'd4, 0));
    opening_rows.push_back(word_row(OP_WRITE, 8'd10, 8'd11, 2'd2));
    opening_rows.push_back(word_row(OP_BLOCK, 8'd10, 8'd10, 2'd0));
    opening_rows.push_back(word_row(OP_BLOCK, 8'd255, 8'd128, 2'd0));
    opening_rows.push_back(word_row(OP_TOUCH, 8'd254, 8'd255, 2'd3));
    opening_rows.push_back(checked_row(OP_SPARE_LAST, 8'd255, 8'd255, 2'd3, 2'd0, 0, 0, 32'd5,
                                       0));
    opening_rows.push_back(checked_row(OP_FILL, 8'd0, 8'd0, 2'd1, 2'd0, 0, 0, 32'd6, 0));
    opening_rows.push_back(checked_row(OP_READ, 8'd128, 8'd77, 2'd0, 2'd1, 0, 0, 32'd6, 0));
    // Zero in both registers acts as a single cell.
    opening_rows.push_back(reg_row(REG_GRID_WIDTH, 9'd0));
    opening_rows.push_back(reg_row(REG_GRID_HEIGHT, 9'd0));
    opening_rows.push_back(checked_row(OP_READ, 8'd0, 8'd0, 2'd0, 2'd1, 0, 0, 32'd6, 0));
    opening_rows.push_back(checked_row(OP_READ, 8'd1, 8'd0, 2'd0, 2'd0, 0, 0, 32'd6, 1));
    opening_rows.push_back(checked_row(OP_WRITE, 8'd0, 8'd1, 2'd2, 2'd0, 0, 0, 32'd6, 1));
    opening_rows.push_back(word_row(OP_BLOCK, 8'd0, 8'd0, 2'd0));
    opening_rows.push_back(word_row(OP_TOUCH, 8'd0, 8'd0, 2'd1));
    opening_rows.push_back(checked_row(OP_FILL, 8'd7, 8'd9, 2'd0, 2'd0, 0, 0, 32'd7, 0));
    opening_rows.push_back(checked_row(OP_READ, 8'd0, 8'd0, 2'd0, 2'd0, 0, 0, 32'd7, 0));
    // Values above the maximum saturate; writes past the register list change nothing.
    opening_rows.push_back(reg_row(REG_GRID_WIDTH, 9'd511));
    opening_rows.push_back(reg_row(REG_GRID_HEIGHT, 9'd300));
    opening_rows.push_back(reg_row(REG_SPARE_LO, 9'd5));
    opening_rows.push_back(reg_row(REG_SPARE_HI, 9'd0));
    opening_rows.push_back(checked_row(OP_READ, 8'd1, 8'd0, 2'd0, 2'd1, 0, 0, 32'd7, 0));
    opening_rows.push_back(checked_row(OP_READ, 8'd200, 8'd200, 2'd0, 2'd1, 0, 0, 32'd7, 0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_rows[i]) begin
      entry = opening_rows[i];
      if (entry.kind == ROW_REG) begin
        drain_results();
        write_reg(entry.reg_index, entry.reg_data);
      end else begin
        send_word(entry.op, entry.col, entry.row, entry.status, entry.hand_checked, entry.hand);
      end
    end

    for (int p = 0; p < $size(PHASE_PLAN); p++) begin
      ph = PHASE_PLAN[p];
      drain_results();
      write_reg(REG_GRID_WIDTH, ph.cols);
      write_reg(REG_GRID_HEIGHT, ph.rows);
      quiet_phase <= ph.quiet;
      w = clip_span(ph.cols);
      h = clip_span(ph.rows);
      anchor_c = 0;
      anchor_r = 0;
      for (int n = 0; n < int'(ph.words); n++) begin
        if (n % 30 == 0) begin
          anchor_c = int'($urandom_range(0, w - 1));
          anchor_r = int'($urandom_range(0, h - 1));
        end
        if (p == HOLD_PHASE && n == 40) begin
          long_hold_req <= 1'b1;
        end
        if (p == PAUSE_PHASE && n == 60) begin
          drain_results();
        end
        send_random_word(w, h, anchor_c, anchor_r);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d writes, %0d fills, %0d reads, %0d blocking and %0d touching queries, %0d %s",
             op_seen[OP_WRITE], op_seen[OP_FILL], op_seen[OP_READ], op_seen[OP_BLOCK],
             op_seen[OP_TOUCH], op_seen[5] + op_seen[6] + op_seen[7], "unknown opcodes.");
    $display("Checked %0d result words (%0d off-grid, %0d blocking) across %0d register writes.",
             results_checked, oor_seen, blocking_seen, reg_writes);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- grid_cell_blocking_query_top.f -----
src/gcbq_pkg.sv
src/gcbq_ring_eval.sv
src/grid_cell_blocking_query_top.sv
tb/sv/tb_top.sv
